// ===== design/lrrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Line range remap table package
// Shared types and constants for the line range remap table.
// ----------------------------------------------------------------------------
`default_nettype none
package lrrt_pkg;

  // Item command codes.
  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_APPEND    = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic [8:0] REG_SLICE_BEGIN = 9'd0;
  localparam logic [8:0] REG_SLICE_END   = 9'd1;

  localparam int FILE_SHIFT = 16;

  // One stored range entry.
  typedef struct packed {
    logic [16:0] rstart;
    logic [16:0] rend;
    logic [15:0] step;
    logic [15:0] tstart;
    logic [15:0] file;
  } entry_t;

endpackage
`default_nettype wire

// ===== design/lrrt_div_cell.sv =====
// ----------------------------------------------------------------------------
// Restoring divider cell
// One cell of the divider row: one quotient bit per cycle, handed onwards.
// ----------------------------------------------------------------------------
`default_nettype none
module lrrt_div_cell #(
  parameter int BIT = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        v_in,
  input  wire logic [16:0] rem_in,
  input  wire logic [16:0] quo_in,
  input  wire logic [15:0] div_in,
  output logic             v_out,
  output logic [16:0]      rem_out,
  output logic [16:0]      quo_out,
  output logic [15:0]      div_out
);

  logic [33:0] trial;
  logic [33:0] dshift;

  // Compare the remainder against the divisor shifted to this cell's bit.
  always_comb begin
    dshift = {18'd0, div_in} << BIT;
    trial  = {17'd0, rem_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out <= 1'b0;
    end else begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    div_out <= div_in;
    if (trial >= dshift) begin
      rem_out <= 17'(trial - dshift);
      quo_out <= quo_in | (17'd1 << BIT);
    end else begin
      rem_out <= rem_in;
      quo_out <= quo_in;
    end
  end

endmodule
`default_nettype wire

// ===== design/line_range_remap_table.sv =====
// A translate item stalls the input until it is done: it scans the slice and, on a
// match, runs the 17-cell divider row, checks the key and loads the output; clear,
// append and no-op items do not stall the input. A translate waits in the key stage
// while the output register is still full, and the input stays stalled meanwhile,
// so a waiting result blocks other items.
// Reset (synchronous, rst_n low) clears counts, last key and slice registers.
`default_nettype none
module line_range_remap_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [16:0] in_seg_jpls_start,
  input  wire logic [16:0] in_seg_jpls_end,
  input  wire logic [15:0] in_seg_step,
  input  wire logic [15:0] in_seg_target_start,
  input  wire logic [15:0] in_seg_file,
  input  wire logic [16:0] in_query_line,
  input  wire logic [63:0] in_query_location,
  input  wire logic        in_first_of_table,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_out_location,
  output logic [31:0]      out_line_key
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NC = 17;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_DIV  = 6'b000100,
    S_WAIT = 6'b001000,
    S_KEY  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r;
  logic [8:0] slice_begin_r, slice_end_r;
  logic [CW-1:0] count_r;
  logic [31:0] last_key_r;
  logic [16:0] line_r;
  logic [63:0] loc_r;
  logic [CW-1:0] idx_r, stop_r;
  logic rd_v_r;
  lrrt_pkg::entry_t mem [TABLE_DEPTH];
  lrrt_pkg::entry_t rd_r, hit_r;
  logic [31:0] key_r;
  logic [CW-1:0] stop_c;
  logic hit_c;

  // Divider row wiring.
  logic        dv   [NC+1];
  logic [16:0] drem [NC+1];
  logic [16:0] dquo [NC+1];
  logic [15:0] ddiv [NC+1];

  assign in_stall = (state_r != S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_begin_r <= 9'd0;
      slice_end_r   <= 9'd0;
    end else if (cfg_we) begin
      if (cfg_index == lrrt_pkg::REG_SLICE_BEGIN) slice_begin_r <= cfg_wdata;
      if (cfg_index == lrrt_pkg::REG_SLICE_END) slice_end_r <= cfg_wdata;
    end
  end

  // Search limit: the lesser of the slice end and the entry count.
  always_comb begin
    if ({23'd0, slice_end_r} < 32'(count_r)) stop_c = CW'(slice_end_r);
    else stop_c = count_r;
  end

  // Table memory: written on append, read one entry a cycle while scanning.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && !in_stall &&
        in_command == lrrt_pkg::CMD_APPEND && 32'(count_r) < TABLE_DEPTH) begin
      mem[count_r[AW-1:0]] <= '{in_seg_jpls_start, in_seg_jpls_end,
        (in_seg_step == 16'd0) ? 16'd1 : in_seg_step, in_seg_target_start,
        in_seg_file};
    end
    rd_r <= mem[idx_r[AW-1:0]];
  end

  assign hit_c = rd_v_r && (line_r >= rd_r.rstart) && (line_r <= rd_r.rend);

  // Divider cells, most significant quotient bit first.
  assign dv[0]   = (state_r == S_SCAN) && hit_c;
  assign drem[0] = line_r - rd_r.rstart;
  assign dquo[0] = 17'd0;
  assign ddiv[0] = rd_r.step;
  for (genvar g = 0; g < NC; g++) begin : g_div
    lrrt_div_cell #(.BIT(NC - 1 - g)) u_cell (
      .clk(clk), .rst_n(rst_n), .v_in(dv[g]), .rem_in(drem[g]),
      .quo_in(dquo[g]), .div_in(ddiv[g]), .v_out(dv[g+1]),
      .rem_out(drem[g+1]), .quo_out(dquo[g+1]), .div_out(ddiv[g+1]));
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      last_key_r <= 32'd0;
      out_valid  <= 1'b0;
      rd_v_r     <= 1'b0;
      idx_r      <= '0;
      stop_r     <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            line_r <= in_query_line;
            loc_r  <= in_query_location;
            case (in_command)
              lrrt_pkg::CMD_CLEAR: count_r <= '0;
              lrrt_pkg::CMD_APPEND: begin
                if (32'(count_r) < TABLE_DEPTH) count_r <= count_r + CW'(1);
              end
              lrrt_pkg::CMD_TRANSLATE: begin
                if (in_first_of_table) last_key_r <= 32'd0;
                idx_r   <= CW'(slice_begin_r);
                stop_r  <= stop_c;
                rd_v_r  <= 1'b0;
                state_r <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (hit_c) begin
            hit_r   <= rd_r;
            rd_v_r  <= 1'b0;
            state_r <= S_DIV;
          end else if (32'(idx_r) >= 32'(stop_r) ||
                       32'(slice_begin_r) >= 32'(stop_r)) begin
            if (!rd_v_r || 32'(idx_r) >= 32'(stop_r)) begin
              rd_v_r  <= 1'b0;
              state_r <= rd_v_r || 32'(slice_begin_r) >= 32'(stop_r)
                         ? S_IDLE : S_SCAN;
            end
          end else begin
            rd_v_r <= 1'b1;
            idx_r  <= idx_r + CW'(1);
          end
        end
        S_DIV: state_r <= S_WAIT;
        S_WAIT: begin
          if (dv[NC]) begin
            key_r <= 32'({16'd0, hit_r.tstart}) + 32'({15'd0, dquo[NC]}) +
                     ({16'd0, hit_r.file} << lrrt_pkg::FILE_SHIFT);
            state_r <= S_KEY;
          end
        end
        // A new key is loaded only once the output register is free.
        S_KEY: begin
          if (key_r == last_key_r) state_r <= S_IDLE;
          else if (!out_valid) begin
            last_key_r       <= key_r;
            out_line_key     <= key_r;
            out_out_location <= loc_r;
            state_r          <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result only leaves the output stage.
  a_out_from_key: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT) else $error("stray result");
  // No item is taken while a translate is in flight.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  // The entry count never passes the depth.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_DEPTH) else $error("count overflow");

endmodule
`default_nettype wire
